>>> design/lrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg: shared types for the link replay buffer
// Operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
package lrb_pkg;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_REPLAY = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

>>> design/lrb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_mem: entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lrb_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/lrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_ctrl: command sequencer for the link replay buffer
// Appends on store; otherwise scans the entries oldest first, compacting
// survivors in place on remove and flush.
// ----------------------------------------------------------------------------
module lrb_ctrl
  import lrb_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int SEQ_BITS  = 16,
  parameter int DATA_BITS = 64,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int ENT_W    = SEQ_BITS + DATA_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_operation,
  input  logic [SEQ_BITS-1:0]  in_sequence_req,
  input  logic [SEQ_BITS-1:0]  in_msg_sequence,
  input  logic [DATA_BITS-1:0] in_msg_payload,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [DATA_BITS-1:0] out_replay_payload,
  output logic [CNT_W-1:0]     out_fill_count,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output logic [ENT_W-1:0]     mem_wdata,
  output logic                 mem_re,
  output logic [IDX_W-1:0]     mem_raddr,
  input  logic [ENT_W-1:0]     mem_rdata
);

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [SEQ_BITS-1:0]  req_r, req_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rd_r, rd_nxt;
  logic [CNT_W-1:0]     wr_r, wr_nxt;
  logic                 pend_r, pend_nxt;
  logic                 hit_r, hit_nxt;
  logic [DATA_BITS-1:0] pay_r, pay_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [DATA_BITS-1:0] out_payload_r, out_payload_nxt;

  logic                 accept;
  logic                 scan_done;
  logic [SEQ_BITS-1:0]  ent_seq;
  logic [DATA_BITS-1:0] ent_data;
  logic                 drop;

  assign accept    = start && (state_r == S_IDLE);
  assign scan_done = (state_r == S_SCAN) && !pend_r && (rd_r >= cnt_r);
  assign ent_seq   = mem_rdata[ENT_W-1:DATA_BITS];
  assign ent_data  = mem_rdata[DATA_BITS-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (op_t'(in_operation) != OP_STORE)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt          = op_r;
    req_nxt         = req_r;
    cnt_nxt         = cnt_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    pend_nxt        = pend_r;
    hit_nxt         = hit_r;
    pay_nxt         = pay_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    mem_we          = 1'b0;
    mem_waddr       = cnt_r[IDX_W-1:0];
    mem_wdata       = {in_msg_sequence, in_msg_payload};
    mem_re          = 1'b0;
    mem_raddr       = rd_r[IDX_W-1:0];
    drop            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = op_t'(in_operation);
          req_nxt = in_sequence_req;
          if (op_t'(in_operation) == OP_STORE) begin
            out_valid_nxt   = 1'b1;
            out_payload_nxt = '0;
            if (in_msg_sequence != in_sequence_req) begin
              out_status_nxt = ST_MISMATCH;
            end else if (cnt_r >= CNT_W'(DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_OK;
              mem_we         = 1'b1;
              cnt_nxt        = cnt_r + 1'b1;
            end
          end else begin
            rd_nxt   = '0;
            wr_nxt   = '0;
            pend_nxt = 1'b0;
            hit_nxt  = 1'b0;
            pay_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while the previous one is evaluated
        if (rd_r < cnt_r) begin
          mem_re   = 1'b1;
          rd_nxt   = rd_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          unique case (op_r)
            OP_REPLAY: begin
              if (!hit_r && (ent_seq == req_r)) begin
                hit_nxt = 1'b1;
                pay_nxt = ent_data;
              end
            end
            OP_REMOVE: drop = !hit_r && (ent_seq == req_r);
            OP_FLUSH:  drop = (ent_seq <= req_r);
            default:   drop = 1'b0;
          endcase
          if ((op_r == OP_REMOVE) || (op_r == OP_FLUSH)) begin
            if (drop) begin
              hit_nxt = 1'b1;
            end else begin
              // Move the survivor down to the next packed slot
              mem_we    = 1'b1;
              mem_waddr = wr_r[IDX_W-1:0];
              mem_wdata = mem_rdata;
              wr_nxt    = wr_r + 1'b1;
            end
          end
        end

        if (scan_done) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = hit_r ? ST_OK : ST_NOMATCH;
          out_payload_nxt = pay_r;
          if (op_r != OP_REPLAY) begin
            cnt_nxt = wr_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    req_r         <= req_nxt;
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    hit_r         <= hit_nxt;
    pay_r         <= pay_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_replay_payload = out_payload_r;
  // Count changes only on an accepted store or at the end of a remove or flush, so it is stable while shown
  assign out_fill_count     = cnt_r;

endmodule

>>> design/link_replay_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_replay_buffer: link-level retry buffer
// Holds sent messages in arrival order; serves store, replay, remove and
// cumulative flush commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  command   start / busy         in_operation, in_sequence_req,
//                                 in_msg_sequence, in_msg_payload
//  result    out_valid (strobe)   out_status, out_replay_payload,
//                                 out_fill_count
//
// Store never raises busy; its result strobes in the cycle after it is taken.
// Replay, remove and flush scan the held entries through the single read
// port of the entry memory: busy while one read per held entry is issued
// and evaluated, the result strobing in the cycle after.
// A transfer is taken at any edge with start high and busy low, including
// the cycle in which the previous result is shown. Results cannot be
// stalled. Reset empties the buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
module link_replay_buffer
  import lrb_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int SEQ_BITS  = 16,
  parameter int DATA_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic [SEQ_BITS-1:0]           in_sequence_req,
  input  logic [SEQ_BITS-1:0]           in_msg_sequence,
  input  logic [DATA_BITS-1:0]          in_msg_payload,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [DATA_BITS-1:0]          out_replay_payload,
  output logic [$clog2(DEPTH + 1)-1:0]  out_fill_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int ENT_W = SEQ_BITS + DATA_BITS;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  lrb_ctrl #(
    .DEPTH     (DEPTH),
    .SEQ_BITS  (SEQ_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_sequence_req    (in_sequence_req),
    .in_msg_sequence    (in_msg_sequence),
    .in_msg_payload     (in_msg_payload),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_replay_payload (out_replay_payload),
    .out_fill_count     (out_fill_count),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

  lrb_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
